### sv/ogri_pkg.sv
`timescale 1ns / 1ps
package ogri_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_SPAN   = 16;

  localparam int CELLS     = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CW        = 11;
  localparam int GW        = 9;
  localparam int RW        = 13;
  localparam int R_MAX     = MAX_SPAN * 256;
  localparam int SPW       = $clog2(MAX_SPAN + 1);
  localparam int TA_W      = 2 * SPW;
  localparam int TBL_DEPTH = 1 << TA_W;
  localparam int D2W       = $clog2(2 * MAX_SPAN * MAX_SPAN + 1);

  localparam logic [2:0] MODE_RAY     = 3'd0;
  localparam logic [2:0] MODE_INFLATE = 3'd1;
  localparam logic [2:0] MODE_READ    = 3'd2;
  localparam logic [2:0] MODE_CLEAR   = 3'd3;
  localparam logic [2:0] MODE_WRITE   = 3'd4;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  localparam logic [7:0] OCC_FREE     = 8'd0;
  localparam logic [7:0] OCC_HIT      = 8'd100;
  localparam logic [7:0] OCC_UNKNOWN  = 8'hFF;
  localparam logic [7:0] COST_UNKNOWN = 8'd255;
  localparam logic [7:0] COST_MAX     = 8'd100;
  localparam logic [7:0] COST_ZERO    = 8'd0;
  localparam logic signed [7:0] OBST_TH = 8'sd50;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RAY,
    S_TBL,
    S_TBL_WAIT,
    S_ZERO,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_NB_RD,
    S_NB_WR,
    S_READ_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_SQRT,
    C_DIV,
    C_FIN
  } calc_state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CW-1:0] x,
                                                 input logic [CW-1:0] y);
    cell_addr = ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x));
  endfunction

  function automatic logic in_grid(input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y,
                                   input logic [CW-1:0] w,
                                   input logic [CW-1:0] h);
    in_grid = !x[CW-1] && !y[CW-1] && (unsigned'(x) < w) && (unsigned'(y) < h);
  endfunction

endpackage

### sv/ogri_ram.sv
`timescale 1ns / 1ps
module ogri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ogri_costcalc.sv
`timescale 1ns / 1ps
module ogri_costcalc (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ogri_pkg::D2W-1:0] d2,
  input  logic [ogri_pkg::RW-1:0]  radius,
  output logic                     done,
  output logic [7:0]               cost
);

  ogri_pkg::calc_state_t state, state_next;

  logic [41:0] n;
  logic [23:0] rem;
  logic [20:0] root;
  logic [28:0] dvd;
  logic [12:0] drem;
  logic [28:0] quo;
  logic [4:0]  cnt;
  logic [ogri_pkg::RW-1:0] r;

  logic [23:0] a_op, b_op;
  logic [24:0] diff;
  logic        ge;
  logic [16:0] qc, frac;
  logic [23:0] prod;

  assign diff = {1'b0, a_op} - {1'b0, b_op};
  assign ge   = !diff[24];

  always_comb begin
    state_next = state;
    case (state)
      ogri_pkg::C_IDLE: if (start) state_next = ogri_pkg::C_SQRT;
      ogri_pkg::C_SQRT: if (cnt == 5'd0) state_next = ogri_pkg::C_DIV;
      ogri_pkg::C_DIV:  if (cnt == 5'd0) state_next = ogri_pkg::C_FIN;
      ogri_pkg::C_FIN:  state_next = ogri_pkg::C_IDLE;
      default:          state_next = ogri_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    a_op = 24'd0;
    b_op = 24'd0;
    done = 1'b0;
    qc   = (quo > 29'd65536) ? 17'd65536 : quo[16:0];
    frac = 17'd65536 - qc;
    prod = 24'(frac) * 24'd100;
    cost = prod[23:16];
    case (state)
      ogri_pkg::C_SQRT: begin
        a_op = {rem[21:0], n[41:40]};
        b_op = {1'b0, root, 2'b01};
      end
      ogri_pkg::C_DIV: begin
        a_op = 24'({drem, dvd[28]});
        b_op = 24'(r);
      end
      ogri_pkg::C_FIN: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ogri_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
    case (state)
      ogri_pkg::C_IDLE: begin
        if (start) begin
          n    <= {d2, 32'd0};
          rem  <= 24'd0;
          root <= 21'd0;
          r    <= radius;
          cnt  <= 5'd20;
        end
      end
      ogri_pkg::C_SQRT: begin
        rem  <= ge ? diff[23:0] : a_op;
        root <= {root[19:0], ge};
        n    <= {n[39:0], 2'b00};
        if (cnt == 5'd0) begin
          dvd  <= {root[19:0], ge, 8'd0};
          drem <= 13'd0;
          quo  <= 29'd0;
          cnt  <= 5'd28;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
      ogri_pkg::C_DIV: begin
        drem <= ge ? diff[12:0] : a_op[12:0];
        quo  <= {quo[27:0], ge};
        dvd  <= {dvd[27:0], 1'b0};
        cnt  <= cnt - 5'd1;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    start |-> state == ogri_pkg::C_IDLE)
    else $error("cost unit started while busy");

  assert property (@(posedge clk) disable iff (rst)
    (state == ogri_pkg::C_SQRT && cnt == 5'd0) |=> (state == ogri_pkg::C_DIV && cnt == 5'd28))
    else $error("divide phase did not follow root phase");

  assert property (@(posedge clk) disable iff (rst)
    done |-> cost <= ogri_pkg::COST_MAX)
    else $error("cost above maximum");

endmodule

### sv/occupancy_grid_ray_and_inflate.sv
`timescale 1ns / 1ps
// Occupancy grid with ray marking and cost inflation.
// Input channel (in_valid/in_stall) takes one command beat: mode, two cells and
// a write value. Output channel (out_valid/out_stall) returns one result beat
// per command: occupancy, inflated_cost, in_bounds. Config writes (cfg_we,
// cfg_index, cfg_data) set grid width, height and inflation radius; they take
// effect at once and must be written only while the block is idle; the block
// itself does not enforce this. One command at a time; in_stall stays high
// until the command finishes. Ray: marks one cell per cycle along the line.
// Clear: a sweep over both grids, setting every cell to unknown.
// Inflate: cost table of (span+1)^2 entries, each entry inside the radius
// computed by one shared shift/subtract unit for root and divide and the rest
// written directly, then a cost wipe, a read and check of each grid cell in
// use, and for each obstacle a read and max update per in-grid neighbor and a
// skip per off-grid one (up to 33x33 neighbors at a 16-cell radius).
// After reset both grids are swept to unknown; in_stall is high meanwhile. A
// finished result is held in the output register while the receiver stalls,
// and a new command may be taken while it waits.
module occupancy_grid_ray_and_inflate (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        mode,
  input  logic signed [9:0] x_a,
  input  logic signed [9:0] y_a,
  input  logic signed [9:0] x_b,
  input  logic signed [9:0] y_b,
  input  logic signed [7:0] cell_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] occupancy,
  output logic [7:0]        inflated_cost,
  output logic              in_bounds
);

  localparam int CW  = ogri_pkg::CW;
  localparam int AW  = ogri_pkg::ADDR_W;
  localparam int SPW = ogri_pkg::SPW;

  ogri_pkg::state_t state, state_next;

  logic [ogri_pkg::GW-1:0] grid_width, grid_height;
  logic [ogri_pkg::RW-1:0] inflation_radius_q8;

  logic signed [CW-1:0] cx, cy, ex, ey;
  logic [CW-1:0]        dxr, dyr;
  logic                 sx, sy;
  logic signed [CW:0]   err;
  logic signed [SPW:0]  ox, oy;
  logic [ogri_pkg::RW-1:0]   rsat;
  logic [SPW-1:0]            span;
  logic [2*ogri_pkg::RW-1:0] r2;
  logic [AW-1:0]        sweep, naddr;
  logic                 clr_op;
  logic [7:0]           res_occ, res_cost;
  logic                 res_ok;

  logic                 occ_we, cost_we, tbl_we;
  logic [AW-1:0]        occ_waddr, occ_raddr, cost_waddr, cost_raddr;
  logic [7:0]           occ_wdata, cost_wdata, tbl_wdata;
  logic [7:0]           occ_rdata, cost_rdata, tbl_rdata;
  logic [ogri_pkg::TA_W-1:0] tbl_waddr, tbl_raddr;
  logic                 calc_start, calc_done;
  logic [7:0]           calc_cost;

  logic [CW-1:0]        wcl, hcl;
  logic signed [CW-1:0] xa_e, ya_e, xb_e, yb_e, nx, ny;
  logic signed [CW-1:0] ddx, ddy;
  logic                 in_acc, a_in, b_in, out_free;
  logic                 at_end, step_x, step_y;
  logic signed [CW+1:0] e2;
  logic [SPW-1:0]       ax, ay;
  logic [ogri_pkg::D2W-1:0] d2;
  logic                 off_out, tbl_last, nb_in, nb_last, cell_last, obstacle;
  logic [ogri_pkg::RW-1:0]  r_cfg;
  logic signed [SPW:0]  span_s;

  ogri_ram #(.WIDTH(8), .DEPTH(ogri_pkg::CELLS)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
    .raddr(occ_raddr), .rdata(occ_rdata)
  );

  ogri_ram #(.WIDTH(8), .DEPTH(ogri_pkg::CELLS)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
    .raddr(cost_raddr), .rdata(cost_rdata)
  );

  ogri_ram #(.WIDTH(8), .DEPTH(ogri_pkg::TBL_DEPTH)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  ogri_costcalc u_calc (
    .clk(clk), .rst(rst), .start(calc_start), .d2(d2), .radius(rsat),
    .done(calc_done), .cost(calc_cost)
  );

  always_comb begin
    wcl = (grid_width == '0) ? CW'(1) :
          (grid_width > ogri_pkg::GW'(ogri_pkg::MAX_WIDTH)) ? CW'(ogri_pkg::MAX_WIDTH) :
          CW'(grid_width);
    hcl = (grid_height == '0) ? CW'(1) :
          (grid_height > ogri_pkg::GW'(ogri_pkg::MAX_HEIGHT)) ? CW'(ogri_pkg::MAX_HEIGHT) :
          CW'(grid_height);
    r_cfg = (inflation_radius_q8 > ogri_pkg::RW'(ogri_pkg::R_MAX)) ?
            ogri_pkg::RW'(ogri_pkg::R_MAX) : inflation_radius_q8;
    xa_e = {{(CW-10){x_a[9]}}, x_a};
    ya_e = {{(CW-10){y_a[9]}}, y_a};
    xb_e = {{(CW-10){x_b[9]}}, x_b};
    yb_e = {{(CW-10){y_b[9]}}, y_b};
    ddx  = xb_e - xa_e;
    ddy  = yb_e - ya_e;
    a_in = ogri_pkg::in_grid(xa_e, ya_e, wcl, hcl);
    b_in = ogri_pkg::in_grid(xb_e, yb_e, wcl, hcl);
    in_acc   = in_valid && !in_stall;
    out_free = !out_valid || !out_stall;

    at_end = (cx == ex) && (cy == ey);
    e2     = {err, 1'b0};
    step_x = e2 > -(CW+2)'(signed'({1'b0, dyr}));
    step_y = e2 < (CW+2)'(signed'({1'b0, dxr}));

    ax = ox[SPW] ? SPW'(-ox) : ox[SPW-1:0];
    ay = oy[SPW] ? SPW'(-oy) : oy[SPW-1:0];
    d2 = ogri_pkg::D2W'(ogri_pkg::D2W'(ax) * ogri_pkg::D2W'(ax) +
                        ogri_pkg::D2W'(ay) * ogri_pkg::D2W'(ay));
    off_out  = {d2, 16'd0} > r2;
    span_s   = {1'b0, span};
    tbl_last = (ox == span_s) && (oy == span_s);
    nb_last  = tbl_last;
    nx = cx + CW'(ox);
    ny = cy + CW'(oy);
    nb_in     = ogri_pkg::in_grid(nx, ny, wcl, hcl);
    cell_last = (unsigned'(cx) == wcl - CW'(1)) && (unsigned'(cy) == hcl - CW'(1));
    obstacle  = signed'(occ_rdata) >= ogri_pkg::OBST_TH;
    in_stall  = (state != ogri_pkg::S_IDLE);
  end

  always_comb begin
    state_next = state;
    case (state)
      ogri_pkg::S_CLEAR: begin
        if (sweep == AW'(ogri_pkg::CELLS - 1)) begin
          state_next = clr_op ? ogri_pkg::S_DONE : ogri_pkg::S_IDLE;
        end
      end
      ogri_pkg::S_IDLE: begin
        if (in_acc) begin
          case (mode)
            ogri_pkg::MODE_RAY:
              state_next = (a_in && b_in) ? ogri_pkg::S_RAY : ogri_pkg::S_DONE;
            ogri_pkg::MODE_INFLATE: state_next = ogri_pkg::S_TBL;
            ogri_pkg::MODE_READ:
              state_next = a_in ? ogri_pkg::S_READ_WAIT : ogri_pkg::S_DONE;
            ogri_pkg::MODE_CLEAR: state_next = ogri_pkg::S_CLEAR;
            default: state_next = ogri_pkg::S_DONE;
          endcase
        end
      end
      ogri_pkg::S_RAY: if (at_end) state_next = ogri_pkg::S_DONE;
      ogri_pkg::S_TBL: begin
        if (rsat != '0 && !off_out) begin
          state_next = ogri_pkg::S_TBL_WAIT;
        end else if (tbl_last) begin
          state_next = ogri_pkg::S_ZERO;
        end
      end
      ogri_pkg::S_TBL_WAIT: begin
        if (calc_done) state_next = tbl_last ? ogri_pkg::S_ZERO : ogri_pkg::S_TBL;
      end
      ogri_pkg::S_ZERO: begin
        if (sweep == AW'(ogri_pkg::CELLS - 1)) state_next = ogri_pkg::S_SCAN_RD;
      end
      ogri_pkg::S_SCAN_RD: state_next = ogri_pkg::S_SCAN_CHK;
      ogri_pkg::S_SCAN_CHK: begin
        if (obstacle) state_next = ogri_pkg::S_NB_RD;
        else state_next = cell_last ? ogri_pkg::S_DONE : ogri_pkg::S_SCAN_RD;
      end
      ogri_pkg::S_NB_RD: begin
        if (nb_in) state_next = ogri_pkg::S_NB_WR;
        else if (nb_last) state_next = cell_last ? ogri_pkg::S_DONE : ogri_pkg::S_SCAN_RD;
      end
      ogri_pkg::S_NB_WR: begin
        if (nb_last) state_next = cell_last ? ogri_pkg::S_DONE : ogri_pkg::S_SCAN_RD;
        else state_next = ogri_pkg::S_NB_RD;
      end
      ogri_pkg::S_READ_WAIT: state_next = ogri_pkg::S_DONE;
      ogri_pkg::S_DONE: if (out_free) state_next = ogri_pkg::S_IDLE;
      default: state_next = ogri_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    occ_we     = 1'b0;
    occ_waddr  = ogri_pkg::cell_addr(cx, cy);
    occ_wdata  = ogri_pkg::OCC_FREE;
    occ_raddr  = ogri_pkg::cell_addr(cx, cy);
    cost_we    = 1'b0;
    cost_waddr = naddr;
    cost_wdata = tbl_rdata;
    cost_raddr = ogri_pkg::cell_addr(nx, ny);
    tbl_we     = 1'b0;
    tbl_waddr  = {oy[SPW-1:0], ox[SPW-1:0]};
    tbl_wdata  = ogri_pkg::COST_ZERO;
    tbl_raddr  = {ay, ax};
    calc_start = 1'b0;
    case (state)
      ogri_pkg::S_CLEAR: begin
        occ_we     = 1'b1;
        occ_waddr  = sweep;
        occ_wdata  = ogri_pkg::OCC_UNKNOWN;
        cost_we    = 1'b1;
        cost_waddr = sweep;
        cost_wdata = ogri_pkg::COST_UNKNOWN;
      end
      ogri_pkg::S_IDLE: begin
        occ_raddr  = ogri_pkg::cell_addr(xa_e, ya_e);
        cost_raddr = ogri_pkg::cell_addr(xa_e, ya_e);
        occ_waddr  = ogri_pkg::cell_addr(xa_e, ya_e);
        occ_wdata  = cell_value;
        occ_we     = in_acc && (mode == ogri_pkg::MODE_WRITE) && a_in;
      end
      ogri_pkg::S_RAY: begin
        occ_we    = 1'b1;
        occ_wdata = at_end ? ogri_pkg::OCC_HIT : ogri_pkg::OCC_FREE;
      end
      ogri_pkg::S_TBL: begin
        if (rsat == '0) begin
          tbl_we    = 1'b1;
          tbl_wdata = (d2 == '0) ? ogri_pkg::COST_MAX : ogri_pkg::COST_ZERO;
        end else if (off_out) begin
          tbl_we = 1'b1;
        end else begin
          calc_start = 1'b1;
        end
      end
      ogri_pkg::S_TBL_WAIT: begin
        tbl_we    = calc_done;
        tbl_wdata = calc_cost;
      end
      ogri_pkg::S_ZERO: begin
        cost_we    = 1'b1;
        cost_waddr = sweep;
        cost_wdata = ogri_pkg::COST_ZERO;
      end
      ogri_pkg::S_NB_WR: cost_we = tbl_rdata > cost_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ogri_pkg::S_CLEAR;
      sweep               <= '0;
      clr_op              <= 1'b0;
      out_valid           <= 1'b0;
      grid_width          <= ogri_pkg::GW'(ogri_pkg::MAX_WIDTH);
      grid_height         <= ogri_pkg::GW'(ogri_pkg::MAX_HEIGHT);
      inflation_radius_q8 <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          ogri_pkg::CFG_WIDTH:  grid_width  <= cfg_data[ogri_pkg::GW-1:0];
          ogri_pkg::CFG_HEIGHT: grid_height <= cfg_data[ogri_pkg::GW-1:0];
          ogri_pkg::CFG_RADIUS: inflation_radius_q8 <= cfg_data;
          default: ;
        endcase
      end
      if (state == ogri_pkg::S_CLEAR || state == ogri_pkg::S_ZERO) begin
        sweep <= (sweep == AW'(ogri_pkg::CELLS - 1)) ? '0 : sweep + AW'(1);
      end
      if (state == ogri_pkg::S_IDLE && in_acc) begin
        clr_op <= (mode == ogri_pkg::MODE_CLEAR);
      end
      if (state == ogri_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end

    if (state == ogri_pkg::S_DONE && out_free) begin
      occupancy     <= res_occ;
      inflated_cost <= res_cost;
      in_bounds     <= res_ok;
    end

    case (state)
      ogri_pkg::S_IDLE: begin
        if (in_acc) begin
          res_occ  <= (mode == ogri_pkg::MODE_READ && !a_in) ?
                      ogri_pkg::OCC_UNKNOWN : ogri_pkg::OCC_FREE;
          res_cost <= (mode == ogri_pkg::MODE_READ && !a_in) ?
                      ogri_pkg::COST_UNKNOWN : ogri_pkg::COST_ZERO;
          cx   <= xa_e;
          cy   <= ya_e;
          ex   <= xb_e;
          ey   <= yb_e;
          dxr  <= ddx[CW-1] ? CW'(-ddx) : ddx;
          dyr  <= ddy[CW-1] ? CW'(-ddy) : ddy;
          sx   <= xa_e < xb_e;
          sy   <= ya_e < yb_e;
          err  <= (CW+1)'(ddx[CW-1] ? -ddx : ddx) - (CW+1)'(ddy[CW-1] ? -ddy : ddy);
          ox   <= '0;
          oy   <= '0;
          rsat <= r_cfg;
          span <= SPW'((r_cfg + ogri_pkg::RW'(255)) >> 8);
          r2   <= (2*ogri_pkg::RW)'(r_cfg) * (2*ogri_pkg::RW)'(r_cfg);
          case (mode)
            ogri_pkg::MODE_RAY: res_ok <= a_in && b_in;
            ogri_pkg::MODE_INFLATE, ogri_pkg::MODE_CLEAR: res_ok <= 1'b1;
            ogri_pkg::MODE_READ, ogri_pkg::MODE_WRITE: res_ok <= a_in;
            default: res_ok <= 1'b0;
          endcase
        end
      end
      ogri_pkg::S_RAY: begin
        if (!at_end) begin
          if (step_x) cx <= sx ? cx + CW'(1) : cx - CW'(1);
          if (step_y) cy <= sy ? cy + CW'(1) : cy - CW'(1);
          err <= err - (step_x ? (CW+1)'(dyr) : '0) + (step_y ? (CW+1)'(dxr) : '0);
        end
      end
      ogri_pkg::S_TBL, ogri_pkg::S_TBL_WAIT: begin
        if ((state == ogri_pkg::S_TBL && (rsat == '0 || off_out)) ||
            (state == ogri_pkg::S_TBL_WAIT && calc_done)) begin
          if (ox == span_s) begin
            ox <= '0;
            oy <= oy + (SPW+1)'(1);
          end else begin
            ox <= ox + (SPW+1)'(1);
          end
        end
        cx <= '0;
        cy <= '0;
      end
      ogri_pkg::S_SCAN_CHK, ogri_pkg::S_NB_RD, ogri_pkg::S_NB_WR: begin
        if (state == ogri_pkg::S_SCAN_CHK && obstacle) begin
          ox <= -span_s;
          oy <= -span_s;
        end else if (state == ogri_pkg::S_SCAN_CHK ||
                     (state == ogri_pkg::S_NB_RD && !nb_in) ||
                     state == ogri_pkg::S_NB_WR) begin
          if (state != ogri_pkg::S_SCAN_CHK && !nb_last) begin
            if (ox == span_s) begin
              ox <= -span_s;
              oy <= oy + (SPW+1)'(1);
            end else begin
              ox <= ox + (SPW+1)'(1);
            end
          end else if (unsigned'(cx) == wcl - CW'(1)) begin
            cx <= '0;
            cy <= cy + CW'(1);
          end else begin
            cx <= cx + CW'(1);
          end
        end
        if (state == ogri_pkg::S_NB_RD) naddr <= ogri_pkg::cell_addr(nx, ny);
      end
      ogri_pkg::S_READ_WAIT: begin
        res_occ  <= occ_rdata;
        res_cost <= cost_rdata;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block ready right after taking a beat");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ogri_pkg::S_DONE))
    else $error("result raised outside completion");

  assert property (@(posedge clk) disable iff (rst)
    (occ_we && cost_we) |-> state == ogri_pkg::S_CLEAR)
    else $error("both grids written outside a clear sweep");

endmodule
